[hdl/mbs_pkg.sv]
// Shared types, constants and helpers for the maze backtracker step block.
// No dependencies; imported by every module of the block.
package mbs_pkg;

  localparam int MAX_SIDE = 32;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int CELL_W   = 2 * SIDE_W;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int CNT_W    = CELL_W + 1;
  localparam int WALL_W   = SIDE_W + 2;

  localparam logic [1:0] EV_CARVE   = 2'd0;
  localparam logic [1:0] EV_BACK    = 2'd1;
  localparam logic [1:0] EV_FINISH  = 2'd2;
  localparam logic [1:0] EV_RESTART = 2'd3;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_W = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_S = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_DEC,
    ST_POP
  } state_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        dir;
    logic [SIDE_W-1:0] tr;
    logic [SIDE_W-1:0] tc;
    logic [WALL_W-1:0] wall_row;
    logic [WALL_W-1:0] wall_col;
  } pick_t;

  // 16-bit value mod 3: base-4 digit sum, then a short fold
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

[hdl/mbs_visit_ram.sv]
// Visited map: one 32-bit word per grid row, one write and two read ports.
// Depends on mbs_pkg.
module mbs_visit_ram
  import mbs_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [SIDE_W-1:0]   waddr,
  input  logic [MAX_SIDE-1:0] wdata,
  input  logic [SIDE_W-1:0]   raddr_a,
  input  logic [SIDE_W-1:0]   raddr_b,
  output logic [MAX_SIDE-1:0] rdata_a,
  output logic [MAX_SIDE-1:0] rdata_b
);

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hdl/mbs_stack_ram.sv]
// Path stack: cell indices, one write and one read port.
// Depends on mbs_pkg.
module mbs_stack_ram
  import mbs_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [CELL_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [CELL_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mbs_pick.sv]
// Neighbour selection: eligibility in N, W, E, S order, random pick, wall position.
// Depends on mbs_pkg.
module mbs_pick
  import mbs_pkg::*;
(
  input  logic [SIDE_W-1:0] cur_row,
  input  logic [SIDE_W-1:0] cur_col,
  input  logic [5:0]        side,
  input  logic [3:0]        nbr_vis,
  input  logic [1:0]        rnd_lo,
  input  logic [1:0]        rnd_m3,
  output pick_t             pick
);

  always_comb begin
    logic [5:0] r6;
    logic [5:0] c6;
    logic [3:0] inr;
    logic [3:0] elig;
    logic [2:0] n;
    logic [1:0] want;
    logic [1:0] cnt;
    logic [1:0] sel;
    logic       hit;
    r6 = {1'b0, cur_row};
    c6 = {1'b0, cur_col};
    inr[DIR_N] = (cur_row != '0) && ((r6 - 6'd1) < side) && (c6 < side);
    inr[DIR_W] = (cur_col != '0) && (r6 < side) && ((c6 - 6'd1) < side);
    inr[DIR_E] = (r6 < side) && ((c6 + 6'd1) < side);
    inr[DIR_S] = ((r6 + 6'd1) < side) && (c6 < side);
    elig = inr & ~nbr_vis;
    n = 3'($countones(elig));
    case (n)
      3'd1:    want = 2'd0;
      3'd2:    want = {1'b0, rnd_lo[0]};
      3'd3:    want = rnd_m3;
      default: want = rnd_lo;
    endcase
    cnt = '0;
    sel = '0;
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (elig[k]) begin
        if (!hit && cnt == want) begin
          sel = 2'(k);
          hit = 1'b1;
        end
        cnt = cnt + 2'd1;
      end
    end
    pick.found = (n != '0);
    pick.dir   = sel;
    case (sel)
      DIR_N: begin
        pick.tr = cur_row - 1'b1;
        pick.tc = cur_col;
      end
      DIR_W: begin
        pick.tr = cur_row;
        pick.tc = cur_col - 1'b1;
      end
      DIR_E: begin
        pick.tr = cur_row;
        pick.tc = cur_col + 1'b1;
      end
      default: begin
        pick.tr = cur_row + 1'b1;
        pick.tc = cur_col;
      end
    endcase
    pick.wall_row = WALL_W'(cur_row) + WALL_W'(pick.tr) + WALL_W'(1);
    pick.wall_col = WALL_W'(cur_col) + WALL_W'(pick.tc) + WALL_W'(1);
  end

endmodule

[hdl/maze_backtracker_step.sv]
// Randomized depth-first maze carver, one result beat per command beat.
// Depends on mbs_pkg, mbs_visit_ram, mbs_stack_ram and mbs_pick.
//
// A command beat is taken whenever the walker is idle, even while an earlier
// result still sits in the output register. Restart and finished commands
// end in ST_ROW and a carving step in ST_DEC, each held by any output stall:
// the step reads the north and south rows of the visited map on its two read
// ports, then the current row, then decides and writes back the target row
// and pushes the stack; a backtrack adds one read of the path stack. The
// visited map keeps one valid bit per row, cleared at once by restart, so no
// clearing pass is needed; cell (0,0) always reads as visited.
module maze_backtracker_step
  import mbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,     // side_cells
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,      // rand_word[15:0]
  input  logic        s_tuser,      // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,      // wall_row[6:0], wall_col[13:7], cell_row[18:14],
                                    // cell_col[23:19], visited_total[34:24], zero
  output logic [1:0]  m_tuser       // event_res[1:0]
);

  state_t state, state_next;

  logic [5:0]          side_cells;
  logic [SIDE_W-1:0]   cur_row;
  logic [SIDE_W-1:0]   cur_col;
  logic [CNT_W-1:0]    depth;
  logic [CNT_W-1:0]    count;
  logic [MAX_SIDE-1:0] row_valid;
  logic                cmd_q;
  logic [1:0]          rnd_lo;
  logic [1:0]          rnd_m3;
  logic [MAX_SIDE-1:0] n_word;
  logic [MAX_SIDE-1:0] s_word;

  logic [MAX_SIDE-1:0] rdata_a, rdata_b;
  logic [SIDE_W-1:0]   raddr_a;
  logic [CELL_W-1:0]   stk_rdata, stk_raddr;
  logic [CNT_W-1:0]    dpop;

  logic [5:0]          side;
  logic [11:0]         side_sq;
  logic                done_walk;
  logic                slot_free;
  logic                in_fire;
  logic [3:0]          nbr_vis;
  pick_t               pick;
  logic [MAX_SIDE-1:0] old_word, vis_wdata;
  logic [CELL_W-1:0]   pop_cell;

  logic                do_restart, do_carve, do_pop_dec, do_pop_out, out_load;
  logic [1:0]          out_ev;
  logic [WALL_W-1:0]   out_wr, out_wc;
  logic [SIDE_W-1:0]   out_cr, out_cc;
  logic [CNT_W-1:0]    out_cnt;

  assign side      = (side_cells > 6'(MAX_SIDE)) ? 6'(MAX_SIDE) : side_cells;
  assign side_sq   = 12'(side) * 12'(side);
  assign done_walk = 12'(count) >= side_sq;
  assign slot_free = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign dpop      = (depth != '0) ? depth - 1'b1 : '0;
  assign pop_cell  = (depth != '0) ? stk_rdata : '0;

  assign raddr_a   = (state == ST_IDLE) ? cur_row - 1'b1 : cur_row;
  assign stk_raddr = (state == ST_DEC) ? CELL_W'(dpop - 1'b1) : CELL_W'(depth - 1'b1);

  assign nbr_vis[DIR_N] = ((cur_row == SIDE_W'(1)) && (cur_col == '0)) |
                          (row_valid[cur_row - 1'b1] & n_word[cur_col]);
  assign nbr_vis[DIR_W] = ((cur_row == '0) && (cur_col == SIDE_W'(1))) |
                          (row_valid[cur_row] & rdata_a[cur_col - 1'b1]);
  assign nbr_vis[DIR_E] = row_valid[cur_row] & rdata_a[cur_col + 1'b1];
  assign nbr_vis[DIR_S] = row_valid[cur_row + 1'b1] & s_word[cur_col];

  always_comb begin
    case (pick.dir)
      DIR_N:   old_word = n_word;
      DIR_S:   old_word = s_word;
      default: old_word = rdata_a;
    endcase
    vis_wdata = (row_valid[pick.tr] ? old_word : '0) | (MAX_SIDE'(1) << pick.tc);
  end

  mbs_visit_ram u_visit (
    .clk     (clk),
    .we      (do_carve),
    .waddr   (pick.tr),
    .wdata   (vis_wdata),
    .raddr_a (raddr_a),
    .raddr_b (cur_row + 1'b1),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mbs_stack_ram u_stack (
    .clk   (clk),
    .we    (do_carve),
    .waddr (depth[CELL_W-1:0]),
    .wdata ({pick.tr, pick.tc}),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  mbs_pick u_pick (
    .cur_row (cur_row),
    .cur_col (cur_col),
    .side    (side),
    .nbr_vis (nbr_vis),
    .rnd_lo  (rnd_lo),
    .rnd_m3  (rnd_m3),
    .pick    (pick)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        if (!cmd_q || done_walk) begin
          if (slot_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        if (!pick.found) begin
          state_next = ST_POP;
        end else if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_POP: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = (state == ST_IDLE);
    do_restart = 1'b0;
    do_carve   = 1'b0;
    do_pop_dec = 1'b0;
    do_pop_out = 1'b0;
    out_load   = 1'b0;
    out_ev     = EV_FINISH;
    out_wr     = '0;
    out_wc     = '0;
    out_cr     = cur_row;
    out_cc     = cur_col;
    out_cnt    = count;
    case (state)
      ST_ROW: begin
        if (!cmd_q) begin
          do_restart = slot_free;
          out_load   = slot_free;
          out_ev     = EV_RESTART;
          out_cr     = '0;
          out_cc     = '0;
          out_cnt    = CNT_W'(1);
        end else if (done_walk) begin
          out_load = slot_free;
          out_ev   = EV_FINISH;
        end
      end
      ST_DEC: begin
        if (pick.found) begin
          do_carve = slot_free;
          out_load = slot_free;
          out_ev   = EV_CARVE;
          out_wr   = pick.wall_row;
          out_wc   = pick.wall_col;
          out_cr   = pick.tr;
          out_cc   = pick.tc;
          out_cnt  = count + 1'b1;
        end else begin
          do_pop_dec = 1'b1;
        end
      end
      ST_POP: begin
        do_pop_out = slot_free;
        out_load   = slot_free;
        out_ev     = EV_BACK;
        out_cr     = pop_cell[CELL_W-1:SIDE_W];
        out_cc     = pop_cell[SIDE_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      side_cells <= 6'd16;
      cur_row    <= '0;
      cur_col    <= '0;
      depth      <= '0;
      count      <= CNT_W'(1);
      row_valid  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        side_cells <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (do_restart) begin
        row_valid <= '0;
        depth     <= '0;
        cur_row   <= '0;
        cur_col   <= '0;
        count     <= CNT_W'(1);
      end
      if (do_carve) begin
        row_valid[pick.tr] <= 1'b1;
        if (depth < CNT_W'(CELLS)) begin
          depth <= depth + 1'b1;
        end
        count   <= count + 1'b1;
        cur_row <= pick.tr;
        cur_col <= pick.tc;
      end
      if (do_pop_dec) begin
        depth <= dpop;
      end
      if (do_pop_out) begin
        cur_row <= pop_cell[CELL_W-1:SIDE_W];
        cur_col <= pop_cell[SIDE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q  <= s_tuser;
      rnd_lo <= s_tdata[1:0];
      rnd_m3 <= mod3_16(s_tdata);
    end
    if (state == ST_ROW) begin
      n_word <= rdata_a;
      s_word <= rdata_b;
    end
    if (out_load) begin
      m_tuser <= out_ev;
      m_tdata <= {5'd0, out_cnt, out_cc, out_cr, out_wc, out_wr};
    end
  end

  // every stacked cell was counted as visited, plus the start cell
  a_depth_below_count: assert property (@(posedge clk) disable iff (rst)
    depth < count)
    else $error("stack depth reached visited count");

  a_carve_counts: assert property (@(posedge clk) disable iff (rst)
    do_carve |=> count == $past(count) + 1'b1)
    else $error("carve did not bump visited count");

  // a knocked wall lies between two cells: one coordinate even, one odd
  a_wall_parity: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_CARVE) |-> (m_tdata[0] != m_tdata[7]))
    else $error("carved wall not between adjacent cells");

endmodule

[sim/tb_top.sv]
// Testbench for maze_backtracker_step: a scoreboard predicts every result beat of the carver.
// Restart, step and side-register traffic runs under random stalls on both streams.
// Depends on mbs_pkg and the maze_backtracker_step RTL.
`timescale 1ns / 100ps

module tb_top;
  import mbs_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0]  ev;
    logic [6:0]  wall_row;
    logic [6:0]  wall_col;
    logic [4:0]  cell_row;
    logic [4:0]  cell_col;
    logic [10:0] visited;
  } move_t;

  class maze_walk_tracker;
    bit [5:0]        side_reg;
    bit              seen[CELLS];
    bit [CELL_W-1:0] trail[CELLS];
    int              depth;
    int              here;
    int              count;
    move_t           pending_moves[$];
    int              errors;
    int              ev_count[4];
    int              drow[4] = '{-1, 0, 0, 1};
    int              dcol[4] = '{0, -1, 1, 0};

    function new();
      side_reg = 6'd16;
      clear_walk();
    endfunction

    function void clear_walk();
      foreach (seen[i]) seen[i] = 1'b0;
      seen[0] = 1'b1;
      depth = 0;
      here = 0;
      count = 1;
    endfunction

    function void take_command(bit cmd, bit [15:0] rnd);
      int    side;
      int    r;
      int    c;
      int    n;
      int    pick;
      int    target;
      int    tr;
      int    tc;
      int    nr[4];
      int    nc[4];
      move_t m;
      side = (side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg);
      m = '0;
      if (!cmd) begin
        clear_walk();
        m.ev = EV_RESTART;
      end else if (count >= side * side) begin
        m.ev = EV_FINISH;
      end else begin
        r = here / MAX_SIDE;
        c = here % MAX_SIDE;
        n = 0;
        // north, west, east, south
        for (int k = 0; k < 4; k++) begin
          tr = r + drow[k];
          tc = c + dcol[k];
          if (tr >= 0 && tc >= 0 && tr < side && tc < side) begin
            if (!seen[tr * MAX_SIDE + tc]) begin
              nr[n] = tr;
              nc[n] = tc;
              n++;
            end
          end
        end
        if (n > 0) begin
          pick = int'(rnd) % n;
          target = nr[pick] * MAX_SIDE + nc[pick];
          m.wall_row = 7'(r + nr[pick] + 1);
          m.wall_col = 7'(c + nc[pick] + 1);
          trail[depth % CELLS] = CELL_W'(target);
          if (depth < CELLS) depth++;
          seen[target] = 1'b1;
          count++;
          here = target;
          m.ev = EV_CARVE;
        end else begin
          if (depth > 0) depth--;
          here = (depth > 0) ? int'(trail[(depth - 1) % CELLS]) : 0;
          m.ev = EV_BACK;
        end
      end
      m.cell_row = 5'(here / MAX_SIDE);
      m.cell_col = 5'(here % MAX_SIDE);
      m.visited = 11'(count);
      pending_moves.push_back(m);
    endfunction

    function void check_field(string name, logic [10:0] want, logic [10:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_move(logic [39:0] data, logic [1:0] user);
      move_t want;
      if (pending_moves.size() == 0) begin
        errors++;
        $error("result beat with no command outstanding");
        return;
      end
      want = pending_moves.pop_front();
      ev_count[want.ev]++;
      check_field("event_res", 11'(want.ev), 11'(user));
      check_field("wall_row", 11'(want.wall_row), 11'(data[6:0]));
      check_field("wall_col", 11'(want.wall_col), 11'(data[13:7]));
      check_field("cell_row", 11'(want.cell_row), 11'(data[18:14]));
      check_field("cell_col", 11'(want.cell_col), 11'(data[23:19]));
      check_field("visited_total", want.visited, data[34:24]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  maze_walk_tracker walk = new();
  int gap_odds = 0;
  int stall_odds = 0;
  int stall_left = 0;
  int beats_sent = 0;
  int sides_used = 0;
  int cycle_count = 0;

  maze_backtracker_step i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      walk.check_move(m_tdata, m_tuser);
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    m_tready <= (stall_left == 0);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("** maze_backtracker_step: FAILED **");
    $finish;
  end

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_command(input bit cmd, input logic [15:0] rnd);
    int gap;
    gap = 0;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      gap = $urandom_range(1, 19);
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= rnd;
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    walk.take_command(cmd, rnd);
    beats_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (walk.pending_moves.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_side(input logic [5:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    walk.side_reg = v;
    sides_used++;
  endtask

  initial begin
    int side;
    int eff;
    int steps;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: out of reset, extremes of the word, odd sides, side change mid-walk
    gap_odds = 5;
    stall_odds = 10;
    send_command(1'b1, 16'hFFFF);
    send_command(1'b0, 16'h0000);
    send_command(1'b1, 16'h0000);
    send_command(1'b1, 16'hFFFF);
    send_command(1'b1, 16'h8000);
    send_command(1'b1, 16'h5555);
    send_command(1'b1, 16'hAAAA);
    set_side(6'd63);
    send_command(1'b1, 16'h0000);
    send_command(1'b1, 16'hFFFF);
    set_side(6'd0);
    send_command(1'b1, 16'h0001);
    send_command(1'b0, 16'hFFFF);
    send_command(1'b1, 16'h0000);
    set_side(6'd1);
    send_command(1'b1, 16'hFFFF);
    set_side(6'd2);
    send_command(1'b0, 16'h0000);
    for (int i = 0; i < 6; i++) send_command(1'b1, (i % 2) ? 16'hFFFF : 16'h0000);
    set_side(6'd3);
    send_command(1'b0, 16'h0000);
    for (int i = 0; i < 4; i++) send_command(1'b1, rand_word());

    // random walks, mostly small grids run to completion
    while (beats_sent < 810) begin
      case ($urandom_range(0, 9))
        0:       side = 32;
        1:       side = 3;
        2:       side = $urandom_range(33, 63);
        3:       side = $urandom_range(0, 2);
        4:       side = $urandom_range(9, 32);
        default: side = $urandom_range(3, 8);
      endcase
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        default: gap_odds = 10;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_odds = 0;
        1:       stall_odds = 6;
        default: stall_odds = 16;
      endcase
      set_side(6'(side));
      if ($urandom_range(0, 4) != 0) send_command(1'b0, rand_word());
      eff = (side > MAX_SIDE) ? MAX_SIDE : side;
      steps = 2 * eff * eff + 4;
      if (steps > 160) steps = $urandom_range(40, 160);
      for (int i = 0; i < steps && beats_sent < 810; i++) begin
        if ($urandom_range(0, 59) == 0) send_command(1'b0, rand_word());
        else send_command(1'b1, rand_word());
      end
    end

    // closing stretch at full rate
    gap_odds = 0;
    stall_odds = 0;
    set_side(6'd4);
    send_command(1'b0, rand_word());
    for (int i = 0; i < 40; i++) send_command(1'b1, rand_word());
    settle();
    repeat (10) @(posedge clk);

    if (walk.pending_moves.size() != 0) begin
      walk.errors++;
      $error("%0d expected results never arrived", walk.pending_moves.size());
    end
    $display("%0d command beats over %0d side settings: %0d carves, %0d backtracks,",
             beats_sent, sides_used, walk.ev_count[EV_CARVE], walk.ev_count[EV_BACK]);
    $display("%0d finished steps, %0d restarts, %0d mismatches",
             walk.ev_count[EV_FINISH], walk.ev_count[EV_RESTART], walk.errors);
    if (walk.errors == 0) begin
      $display("** maze_backtracker_step: PASSED **");
    end else begin
      $display("** maze_backtracker_step: FAILED **");
    end
    $finish;
  end

endmodule
